@@ src/efl_pkg.sv @@
// Package for the explicit free-list heap allocator.
// Constants, types and state codes; no dependencies.
package efl_pkg;

  localparam int HEAP_BYTES = 65536;
  localparam int PAGE_BYTES = 4096;
  localparam int WORD_BYTES = 8;
  localparam int HEAP_WORDS = HEAP_BYTES / WORD_BYTES;
  localparam int AW = $clog2(HEAP_WORDS);
  localparam int WSH = $clog2(WORD_BYTES);
  localparam int MIN_BLK = 4 * WORD_BYTES;
  localparam int WALK_MAX = HEAP_BYTES / (4 * WORD_BYTES) + 4;
  localparam int WCW = $clog2(WALK_MAX + 1);

  localparam logic [31:0] T_USED = 32'd1;
  localparam logic [31:0] T_PREV = 32'd2;
  localparam logic [31:0] W32 = 32'(WORD_BYTES);
  localparam logic [31:0] MB32 = 32'(MIN_BLK);
  localparam logic [31:0] PG_MASK = 32'(PAGE_BYTES - 1);
  localparam logic [31:0] TOP_INIT = 32'(2 * WORD_BYTES + MIN_BLK);
  localparam logic [WCW-1:0] WALK_LIM = WCW'(WALK_MAX);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE, S_INIT, S_DONE,
    // malloc
    S_FF_RD, S_FF_CHK, S_FF_NX, S_GROW_RD, S_GROW_W, S_GROW_W2, S_GROW_W3, S_GROW_FF,
    S_AL_SPLIT, S_AL_SP1, S_AL_SP2, S_AL_WHOLE, S_AL_NB, S_AL_NBW, S_AL_RM,
    // free
    S_FR_RD, S_FR_W, S_FR_NB, S_FR_NBW, S_FR_FT,
    // list insert
    S_LI_1, S_LI_2, S_LI_3,
    // list remove
    S_LR_RN, S_LR_RP, S_LR_W1, S_LR_W2,
    // merge
    S_MG_HD, S_MG_B0, S_MG_B1, S_MG_B2, S_MG_B3, S_MG_F1, S_MG_F2, S_MG_END,
    S_MG_W1, S_MG_W2
  } state_t;

  function automatic logic [31:0] bsize(input logic [31:0] w);
    return w & ~32'd7;
  endfunction

endpackage

@@ src/explicit_free_list_heap_allocator.sv @@
// Top level of the explicit free-list heap allocator.
// Depends on efl_pkg and efl_ram.
//
// One command at a time: pulse start with op and its operands while busy is
// low. An allocate (op 0) or a free (op 1) then runs a sequencer over one
// single-port heap RAM, at most one word read or written per cycle, and finishes with
// a one-cycle done strobe carrying result_addr and status; the receiver cannot
// stall it. Latency is data dependent and set by the RAM port: it grows with
// each free-list block visited by the first-fit walk and each neighbor merged,
// on top of the header, footer and link updates. Growing the heap adds its
// header, footer and end-marker writes plus a second walk. A zero-size request
// or an out-of-range free gives done in the cycle right after the beat.
// After reset an init pass writes the initial block layout (busy is high).
module explicit_free_list_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [15:0] req_bytes,
  input  logic [15:0] payload_addr,
  output logic        done,
  output logic [15:0] result_addr,
  output logic [1:0]  status
);

  efl_pkg::state_t state, state_next, lr_ret_st, li_ret_st, mg_ret_st;

  // datapath registers
  logic [31:0] free_head, heap_top;
  logic [31:0] need, blk, bs, tmp, cur, nx, pv, old_sz, new_sz, mstart, rmv, ins;
  logic [efl_pkg::WCW-1:0] cnt;
  logic [2:0]  icnt;
  logic        regrown;
  logic [1:0]  st_r;
  logic [15:0] res_r;

  // memory port
  logic                   we;
  logic [31:0]            maddr, wdata, rdata;

  // decode helpers
  logic [31:0] hsz, pay_c, req_sz, need_c, grow_tot;
  logic [32:0] grow_end;
  logic        fit, split_ok, pa_bad, grow_ok, ff_end, fr_nb, al_nb, mg_back, mg_fwd;

  efl_ram #(.WIDTH(32), .DEPTH(efl_pkg::HEAP_WORDS)) u_heap (
    .clk(clk), .we(we), .addr(maddr[efl_pkg::AW+efl_pkg::WSH-1:efl_pkg::WSH]),
    .wdata(wdata), .rdata(rdata)
  );

  assign hsz      = efl_pkg::bsize(rdata);
  assign pay_c    = cur + efl_pkg::W32;
  assign req_sz   = {16'd0, req_bytes} + efl_pkg::W32;
  // header word added, rounded to 8 bytes, minimum block enforced
  assign need_c   = (req_sz <= efl_pkg::MB32) ? efl_pkg::MB32 :
                    ((req_sz + 32'd7) & ~32'd7);
  assign pa_bad   = ({16'd0, payload_addr} < (efl_pkg::W32 << 1)) ||
                    ({16'd0, payload_addr} >= heap_top);
  // growth in whole pages
  assign grow_tot = (need + efl_pkg::PG_MASK) & ~efl_pkg::PG_MASK;
  assign grow_end = {1'b0, heap_top} + {1'b0, grow_tot};
  assign grow_ok  = (grow_end <= 33'(efl_pkg::HEAP_BYTES));
  assign fit      = (hsz >= need);
  assign split_ok = ((hsz - need) >= efl_pkg::MB32);
  assign ff_end   = (cur == 32'd0) || (cnt == efl_pkg::WALK_LIM);
  // a neighbor header below heap_top - 1 is retagged; the end marker qualifies
  assign fr_nb    = ((blk + hsz) < (heap_top - 32'd1));
  assign al_nb    = ((blk + bs) < (heap_top - 32'd1));
  assign mg_back  = ((rdata & efl_pkg::T_PREV) == 32'd0) && (cnt != efl_pkg::WALK_LIM);
  assign mg_fwd   = ((rdata & efl_pkg::T_USED) == 32'd0) && (cnt != efl_pkg::WALK_LIM);

  assign busy        = (state != efl_pkg::S_IDLE);
  assign done        = (state == efl_pkg::S_DONE);
  assign result_addr = res_r;
  assign status      = st_r;

  // RAM port: each state issues at most one access; a read returns in the
  // next state.
  always_comb begin
    we = 1'b0;
    maddr = 32'd0;
    wdata = 32'd0;
    case (state)
      efl_pkg::S_INIT: begin
        we = 1'b1;
        case (icnt)
          3'd0: begin maddr = efl_pkg::W32; wdata = efl_pkg::MB32 | efl_pkg::T_PREV; end
          3'd1: begin maddr = 2 * efl_pkg::W32; wdata = 32'd0; end
          3'd2: begin maddr = 3 * efl_pkg::W32; wdata = 32'd0; end
          3'd3: begin maddr = 4 * efl_pkg::W32; wdata = efl_pkg::MB32 | efl_pkg::T_PREV; end
          default: begin maddr = 5 * efl_pkg::W32; wdata = efl_pkg::T_USED; end
        endcase
      end
      efl_pkg::S_FF_RD:    maddr = cur;
      efl_pkg::S_FF_CHK:   maddr = pay_c;
      efl_pkg::S_GROW_RD:  maddr = heap_top - efl_pkg::W32;
      efl_pkg::S_GROW_W: begin
        we = 1'b1; maddr = blk; wdata = bs | (rdata & efl_pkg::T_PREV);
      end
      efl_pkg::S_GROW_W2: begin we = 1'b1; maddr = blk + bs - efl_pkg::W32; wdata = tmp; end
      efl_pkg::S_GROW_W3: begin we = 1'b1; maddr = blk + bs; wdata = efl_pkg::T_USED; end
      efl_pkg::S_AL_SPLIT: begin
        we = 1'b1; maddr = blk; wdata = need | (tmp & efl_pkg::T_PREV) | efl_pkg::T_USED;
      end
      efl_pkg::S_AL_SP1: begin
        we = 1'b1; maddr = blk + need; wdata = (bs - need) | efl_pkg::T_PREV;
      end
      efl_pkg::S_AL_SP2: begin
        we = 1'b1; maddr = blk + bs - efl_pkg::W32; wdata = (bs - need) | efl_pkg::T_PREV;
      end
      efl_pkg::S_AL_WHOLE: begin we = 1'b1; maddr = blk; wdata = tmp | efl_pkg::T_USED; end
      efl_pkg::S_AL_NB:    maddr = blk + bs;
      efl_pkg::S_AL_NBW: begin we = 1'b1; maddr = blk + bs; wdata = rdata | efl_pkg::T_PREV; end
      efl_pkg::S_FR_RD:    maddr = blk;
      efl_pkg::S_FR_W: begin we = 1'b1; maddr = blk; wdata = rdata & ~efl_pkg::T_USED; end
      efl_pkg::S_FR_NB:    maddr = blk + bs;
      efl_pkg::S_FR_NBW: begin we = 1'b1; maddr = blk + bs; wdata = rdata & ~efl_pkg::T_PREV; end
      efl_pkg::S_FR_FT: begin we = 1'b1; maddr = blk + bs - efl_pkg::W32; wdata = tmp; end
      efl_pkg::S_LI_1: begin we = 1'b1; maddr = ins + efl_pkg::W32; wdata = free_head; end
      efl_pkg::S_LI_2: begin we = 1'b1; maddr = free_head + 2 * efl_pkg::W32; wdata = ins; end
      efl_pkg::S_LI_3: begin we = 1'b1; maddr = ins + 2 * efl_pkg::W32; wdata = 32'd0; end
      efl_pkg::S_LR_RN:    maddr = rmv + efl_pkg::W32;
      efl_pkg::S_LR_RP:    maddr = rmv + 2 * efl_pkg::W32;
      efl_pkg::S_LR_W1: begin
        we = (nx != 32'd0); maddr = nx + 2 * efl_pkg::W32; wdata = rdata;
      end
      efl_pkg::S_LR_W2: begin we = 1'b1; maddr = pv + efl_pkg::W32; wdata = nx; end
      efl_pkg::S_MG_HD:    maddr = blk;
      efl_pkg::S_MG_B1:    maddr = cur;
      efl_pkg::S_MG_B2:    maddr = cur - efl_pkg::W32;
      efl_pkg::S_MG_F1:    maddr = cur;
      efl_pkg::S_MG_W1: begin we = 1'b1; maddr = mstart; wdata = new_sz | efl_pkg::T_PREV; end
      efl_pkg::S_MG_W2: begin
        we = 1'b1; maddr = cur - efl_pkg::W32; wdata = new_sz | efl_pkg::T_PREV;
      end
      default: ;
    endcase
  end

  // next state; list insert, list remove and merge are shared subroutines
  // that return through li_ret_st, lr_ret_st and mg_ret_st
  always_comb begin
    state_next = state;
    case (state)
      efl_pkg::S_INIT:     if (icnt == 3'd4) state_next = efl_pkg::S_IDLE;
      efl_pkg::S_IDLE: if (start) begin
        if (!op) state_next = (req_bytes == 16'd0) ? efl_pkg::S_DONE : efl_pkg::S_FF_RD;
        else state_next = pa_bad ? efl_pkg::S_DONE : efl_pkg::S_FR_RD;
      end
      efl_pkg::S_DONE:     state_next = efl_pkg::S_IDLE;
      // first fit, grow once when the walk finds nothing
      efl_pkg::S_FF_RD: begin
        if (ff_end) state_next = regrown ? efl_pkg::S_DONE : efl_pkg::S_GROW_RD;
        else state_next = efl_pkg::S_FF_CHK;
      end
      efl_pkg::S_FF_CHK: begin
        if (fit) state_next = split_ok ? efl_pkg::S_AL_SPLIT : efl_pkg::S_AL_WHOLE;
        else state_next = efl_pkg::S_FF_NX;
      end
      efl_pkg::S_FF_NX:    state_next = efl_pkg::S_FF_RD;
      efl_pkg::S_GROW_RD:  state_next = grow_ok ? efl_pkg::S_GROW_W : efl_pkg::S_DONE;
      efl_pkg::S_GROW_W:   state_next = efl_pkg::S_GROW_W2;
      efl_pkg::S_GROW_W2:  state_next = efl_pkg::S_GROW_W3;
      efl_pkg::S_GROW_W3:  state_next = efl_pkg::S_LI_1;
      efl_pkg::S_GROW_FF:  state_next = efl_pkg::S_FF_RD;
      // allocate the block found
      efl_pkg::S_AL_SPLIT: state_next = efl_pkg::S_AL_SP1;
      efl_pkg::S_AL_SP1:   state_next = efl_pkg::S_AL_SP2;
      efl_pkg::S_AL_SP2:   state_next = efl_pkg::S_LI_1;
      efl_pkg::S_AL_WHOLE: state_next = al_nb ? efl_pkg::S_AL_NB : efl_pkg::S_AL_RM;
      efl_pkg::S_AL_NB:    state_next = efl_pkg::S_AL_NBW;
      efl_pkg::S_AL_NBW:   state_next = efl_pkg::S_AL_RM;
      efl_pkg::S_AL_RM:    state_next = efl_pkg::S_LR_RN;
      // free
      efl_pkg::S_FR_RD:    state_next = efl_pkg::S_FR_W;
      efl_pkg::S_FR_W:     state_next = fr_nb ? efl_pkg::S_FR_NB : efl_pkg::S_FR_FT;
      efl_pkg::S_FR_NB:    state_next = efl_pkg::S_FR_NBW;
      efl_pkg::S_FR_NBW:   state_next = efl_pkg::S_FR_FT;
      efl_pkg::S_FR_FT:    state_next = efl_pkg::S_LI_1;
      // list insert at the head
      efl_pkg::S_LI_1: begin
        state_next = (free_head != 32'd0) ? efl_pkg::S_LI_2 : efl_pkg::S_LI_3;
      end
      efl_pkg::S_LI_2:     state_next = efl_pkg::S_LI_3;
      efl_pkg::S_LI_3:     state_next = li_ret_st;
      // list remove; rdata holds the prev link in LR_W1
      efl_pkg::S_LR_RN:    state_next = efl_pkg::S_LR_RP;
      efl_pkg::S_LR_RP:    state_next = efl_pkg::S_LR_W1;
      efl_pkg::S_LR_W1: begin
        if (rmv != free_head && rdata != 32'd0) state_next = efl_pkg::S_LR_W2;
        else state_next = lr_ret_st;
      end
      efl_pkg::S_LR_W2:    state_next = lr_ret_st;
      // merge backward, then forward, then rewrite the merged block
      efl_pkg::S_MG_HD:    state_next = efl_pkg::S_MG_B0;
      efl_pkg::S_MG_B0:    state_next = efl_pkg::S_MG_B1;
      efl_pkg::S_MG_B1:    state_next = efl_pkg::S_MG_B2;
      efl_pkg::S_MG_B2:    state_next = mg_back ? efl_pkg::S_MG_B3 : efl_pkg::S_MG_F1;
      efl_pkg::S_MG_B3:    state_next = efl_pkg::S_LR_RN;
      efl_pkg::S_MG_F1:    state_next = efl_pkg::S_MG_F2;
      efl_pkg::S_MG_F2:    state_next = mg_fwd ? efl_pkg::S_LR_RN : efl_pkg::S_MG_END;
      efl_pkg::S_MG_END:   state_next = (new_sz != old_sz) ? efl_pkg::S_LR_RN : mg_ret_st;
      efl_pkg::S_MG_W1:    state_next = efl_pkg::S_MG_W2;
      efl_pkg::S_MG_W2:    state_next = efl_pkg::S_LI_1;
      default:             state_next = efl_pkg::S_IDLE;
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efl_pkg::S_INIT;
      icnt <= 3'd0;
      free_head <= efl_pkg::W32;
      heap_top <= efl_pkg::TOP_INIT;
    end else begin
      state <= state_next;
      case (state)
        efl_pkg::S_INIT: icnt <= icnt + 3'd1;
        efl_pkg::S_IDLE: if (start) begin
          res_r <= 16'd0;
          st_r <= (!op && req_bytes == 16'd0) ? efl_pkg::ST_ZERO : efl_pkg::ST_OK;
          regrown <= 1'b0;
          need <= need_c;
          cur <= free_head;
          cnt <= '0;
          blk <= {16'd0, payload_addr} - efl_pkg::W32;
        end
        efl_pkg::S_FF_RD: if (ff_end && regrown) st_r <= efl_pkg::ST_OOM;
        efl_pkg::S_FF_CHK: if (fit) begin
          blk <= cur;
          tmp <= rdata;
          bs <= hsz;
          res_r <= pay_c[15:0];
        end
        efl_pkg::S_FF_NX: begin
          cur <= rdata;
          cnt <= cnt + 1'b1;
        end
        efl_pkg::S_GROW_RD: begin
          bs <= grow_tot;
          blk <= heap_top - efl_pkg::W32;
          if (!grow_ok) st_r <= efl_pkg::ST_OOM;
        end
        efl_pkg::S_GROW_W: tmp <= bs | (rdata & efl_pkg::T_PREV);
        efl_pkg::S_GROW_W3: begin
          heap_top <= heap_top + bs;
          ins <= blk;
          li_ret_st <= efl_pkg::S_MG_HD;
          mg_ret_st <= efl_pkg::S_GROW_FF;
        end
        efl_pkg::S_GROW_FF: begin
          cur <= free_head;
          cnt <= '0;
          regrown <= 1'b1;
        end
        efl_pkg::S_AL_SP2: begin
          ins <= blk + need;
          li_ret_st <= efl_pkg::S_AL_RM;
        end
        efl_pkg::S_AL_RM: begin
          rmv <= blk;
          lr_ret_st <= efl_pkg::S_DONE;
        end
        efl_pkg::S_FR_W: begin
          tmp <= rdata & ~efl_pkg::T_USED;
          bs <= hsz;
        end
        efl_pkg::S_FR_FT: begin
          ins <= blk;
          li_ret_st <= efl_pkg::S_MG_HD;
          mg_ret_st <= efl_pkg::S_DONE;
        end
        efl_pkg::S_LI_3: free_head <= ins;
        efl_pkg::S_LR_RP: nx <= rdata;
        efl_pkg::S_LR_W1: begin
          pv <= rdata;
          if (rmv == free_head) free_head <= nx;
        end
        efl_pkg::S_MG_B0: begin
          old_sz <= hsz;
          new_sz <= hsz;
          cur <= blk;
          cnt <= '0;
        end
        efl_pkg::S_MG_B2: if (!mg_back) begin
          mstart <= cur;
          cur <= blk + old_sz;
          cnt <= '0;
        end
        efl_pkg::S_MG_B3: begin
          rmv <= cur - hsz;
          new_sz <= new_sz + hsz;
          cur <= cur - hsz;
          cnt <= cnt + 1'b1;
          lr_ret_st <= efl_pkg::S_MG_B1;
        end
        efl_pkg::S_MG_F2: if (mg_fwd) begin
          rmv <= cur;
          new_sz <= new_sz + hsz;
          cur <= cur + hsz;
          cnt <= cnt + 1'b1;
          lr_ret_st <= efl_pkg::S_MG_F1;
        end
        efl_pkg::S_MG_END: if (new_sz != old_sz) begin
          rmv <= blk;
          lr_ret_st <= efl_pkg::S_MG_W1;
        end
        efl_pkg::S_MG_W2: begin
          ins <= mstart;
          li_ret_st <= mg_ret_st;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/efl_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module efl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ tb/sv/tb_checker.sv @@
`timescale 1ns / 1ps
// Checker for the explicit free-list heap allocator: watches the command and
// result beats, predicts each result from its own heap image. Needs efl_pkg.
module tb_checker
  import efl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        op,
  input  logic [15:0] req_bytes,
  input  logic [15:0] payload_addr,
  input  logic        done,
  input  logic [15:0] result_addr,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending,
  output logic [31:0] top_bytes
);

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  st;
  } heap_result_t;

  heap_result_t expected_results[$];

  // Predicted heap image and list state.
  logic [31:0] heap_img [0:HEAP_WORDS-1];
  logic [31:0] list_head;
  logic [31:0] heap_end;

  assign pending   = expected_results.size();
  assign top_bytes = heap_end;

  function automatic int widx(logic [31:0] a);
    return int'((a >> WSH) % HEAP_WORDS);
  endfunction

  function automatic logic [31:0] peek(logic [31:0] a);
    return heap_img[widx(a)];
  endfunction

  function automatic void poke(logic [31:0] a, logic [31:0] v);
    heap_img[widx(a)] = v;
  endfunction

  function automatic logic [31:0] blk_size(logic [31:0] w);
    return w & ~32'd7;
  endfunction

  function automatic void push_free(logic [31:0] b);
    logic [31:0] h;
    h = list_head;
    poke(b + W32, h);
    if (h != 0) poke(h + 2 * W32, b);
    poke(b + 2 * W32, 32'd0);
    list_head = b;
  endfunction

  function automatic void unlink_free(logic [31:0] b);
    logic [31:0] nx, pv;
    nx = peek(b + W32);
    pv = peek(b + 2 * W32);
    if (nx != 0) poke(nx + 2 * W32, pv);
    if (b == list_head) list_head = nx;
    else if (pv != 0) poke(pv + W32, nx);
  endfunction

  function automatic logic [31:0] find_fit(logic [31:0] need);
    logic [31:0] b;
    int n;
    b = list_head;
    n = 0;
    while (b != 0 && n < WALK_MAX) begin
      if (blk_size(peek(b)) >= need) return b;
      b = peek(b + W32);
      n++;
    end
    return 32'd0;
  endfunction

  function automatic void coalesce(logic [31:0] b);
    logic [31:0] old_sz, new_sz, cur, s, fb, first;
    int n;
    old_sz = blk_size(peek(b));
    new_sz = old_sz;
    cur = b;
    n = 0;
    // backward while the previous block is free
    while ((peek(cur) & T_PREV) == 0 && n < WALK_MAX) begin
      s = blk_size(peek(cur - W32));
      fb = cur - s;
      unlink_free(fb);
      new_sz += s;
      cur = fb;
      n++;
    end
    first = cur;
    cur = b + old_sz;
    n = 0;
    while ((peek(cur) & T_USED) == 0 && n < WALK_MAX) begin
      s = blk_size(peek(cur));
      unlink_free(cur);
      new_sz += s;
      cur += s;
      n++;
    end
    if (new_sz != old_sz) begin
      unlink_free(b);
      poke(first, new_sz | T_PREV);
      poke(cur - W32, new_sz | T_PREV);
      push_free(first);
    end
  endfunction

  function automatic bit extend_heap(logic [31:0] need);
    logic [31:0] total, nb, ptag;
    total = ((need + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    if (longint'(heap_end) + longint'(total) > longint'(HEAP_BYTES)) return 1'b0;
    nb = heap_end - W32;
    ptag = peek(nb) & T_PREV;
    poke(nb, total | ptag);
    poke(nb + total - W32, total | ptag);
    poke(nb + total, T_USED);
    heap_end += total;
    push_free(nb);
    coalesce(nb);
    return 1'b1;
  endfunction

  function automatic heap_result_t predict_heap_op(logic cmd, logic [15:0] req,
                                                   logic [15:0] pa);
    heap_result_t r;
    logic [31:0] sz, need, b, bs, ptag, sp, rest, hdr, s;
    r = '0;
    if (cmd == 1'b0) begin
      if (req == 0) begin
        r.st = ST_ZERO;
        return r;
      end
      sz = 32'(req) + W32;
      need = (sz <= MIN_BLK) ? 32'(MIN_BLK) : ((sz + 32'd7) & ~32'd7);
      b = find_fit(need);
      if (b == 0) begin
        if (!extend_heap(need)) begin
          r.st = ST_OOM;
          return r;
        end
        b = find_fit(need);
        if (b == 0) begin
          r.st = ST_OOM;
          return r;
        end
      end
      ptag = peek(b) & T_PREV;
      bs = blk_size(peek(b));
      if (bs - need >= MIN_BLK) begin
        sp = b + need;
        rest = bs - need;
        poke(b, need | ptag | T_USED);
        poke(sp, rest | T_PREV);
        poke(sp + rest - W32, rest | T_PREV);
        push_free(sp);
      end else begin
        poke(b, peek(b) | T_USED);
        if (b + bs < heap_end - 1) poke(b + bs, peek(b + bs) | T_PREV);
      end
      unlink_free(b);
      r.addr = 16'(b + W32);
    end else begin
      // out-of-range frees are dropped
      if (32'(pa) < 2 * W32 || 32'(pa) >= heap_end) return r;
      b = 32'(pa) - W32;
      hdr = peek(b) & ~T_USED;
      poke(b, hdr);
      s = blk_size(hdr);
      if (b + s < heap_end - 1) poke(b + s, peek(b + s) & ~T_PREV);
      poke(b + s - W32, hdr);
      push_free(b);
      coalesce(b);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t want;
    if (rst) begin
      for (int i = 0; i < HEAP_WORDS; i++) heap_img[i] = '0;
      poke(W32, MIN_BLK | T_PREV);
      poke(2 * W32, 32'd0);
      poke(3 * W32, 32'd0);
      poke(W32 + MIN_BLK - W32, MIN_BLK | T_PREV);
      poke(W32 + MIN_BLK, T_USED);
      list_head = W32;
      heap_end = 2 * W32 + MIN_BLK;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      // result beat first, so the oldest expectation is compared
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result addr=%0d status=%0d", $time,
                   result_addr, status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.addr !== result_addr || want.st !== status) begin
            $display("%0t: mismatch expected addr=%0d status=%0d, actual addr=%0d status=%0d",
                     $time, want.addr, want.st, result_addr, status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_heap_op(op, req_bytes, payload_addr));
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the heap allocator testbench: clock, reset, command stimulus, verdict.
// Needs efl_pkg, the allocator and tb_checker.
module tb_top;

  localparam int IDLE_LIMIT = 200000;  // cycles without any beat
  localparam int N_RANDOM = 400;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        op;
  logic [15:0] req_bytes;
  logic [15:0] payload_addr;
  logic        done;
  logic [15:0] result_addr;
  logic [1:0]  status;
  int          fail_count;
  int          pending;
  logic [31:0] top_bytes;

  int          gap_pct;      // chance of a gap before a command beat
  int          idle_cycles;
  logic [15:0] live_blocks[$];  // payload offsets handed out and not yet freed

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  explicit_free_list_heap_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .req_bytes(req_bytes), .payload_addr(payload_addr), .done(done),
    .result_addr(result_addr), .status(status)
  );

  tb_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .req_bytes(req_bytes), .payload_addr(payload_addr), .done(done),
    .result_addr(result_addr), .status(status), .fail_count(fail_count),
    .pending(pending), .top_bytes(top_bytes)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Collect every block the allocator hands out; only those get freed, so
  // the heap never walks into words that were never written.
  always @(posedge clk) begin
    if (!rst && done && status == efl_pkg::ST_OK && result_addr != 0)
      live_blocks.push_back(result_addr);
  end

  // Watchdog: no command or result beat for too long ends the run.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One command beat; start stays high into the next beat unless a gap falls.
  task automatic send_cmd(logic cmd, logic [15:0] req, logic [15:0] pa);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    op <= cmd;
    req_bytes <= req;
    payload_addr <= pa;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic free_live(int idx);
    logic [15:0] pa;
    if (idx < live_blocks.size()) begin
      pa = live_blocks[idx];
      live_blocks.delete(idx);
      send_cmd(OP_FREE, 16'($urandom), pa);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly well-formed alloc/free traffic; some zero, huge and stray frees.
  task automatic random_cmd;
    int r;
    logic [15:0] pa;
    r = $urandom_range(99);
    if (r < 45 && live_blocks.size() > 0) begin
      free_live($urandom_range(live_blocks.size() - 1));
    end else if (r < 50) begin
      // free outside the heap: below the first payload or past the top
      if (top_bytes <= 32'd65535 && $urandom_range(1))
        pa = 16'($urandom_range(65535, top_bytes));
      else
        pa = 16'($urandom_range(15));
      send_cmd(OP_FREE, 16'($urandom), pa);
    end else if (r < 53) begin
      send_cmd(OP_ALLOC, 16'($urandom), 16'($urandom));
    end else if (r < 56) begin
      send_cmd(OP_ALLOC, 16'd0, 16'($urandom));
    end else if (r < 66) begin
      send_cmd(OP_ALLOC, 16'($urandom_range(4000, 1)), 16'($urandom));
    end else begin
      send_cmd(OP_ALLOC, 16'($urandom_range(256, 1)), 16'($urandom));
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    op <= OP_ALLOC;
    req_bytes <= '0;
    payload_addr <= '0;
    gap_pct = 25;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero size, minimum and just-over sizes, growth, heap
    // exhausted, frees out of range, then merges on both sides.
    send_cmd(OP_ALLOC, 16'd0, 16'd0);
    send_cmd(OP_ALLOC, 16'd1, 16'hffff);
    send_cmd(OP_ALLOC, 16'd24, 16'd0);
    send_cmd(OP_ALLOC, 16'd25, 16'd0);
    send_cmd(OP_ALLOC, 16'd100, 16'd0);
    send_cmd(OP_ALLOC, 16'd100, 16'd0);
    send_cmd(OP_ALLOC, 16'd4096, 16'd0);
    send_cmd(OP_ALLOC, 16'hffff, 16'd0);
    send_cmd(OP_FREE, 16'hffff, 16'd0);
    send_cmd(OP_FREE, 16'd0, 16'd15);
    send_cmd(OP_FREE, 16'd0, 16'hffff);
    drain();
    free_live(1);
    free_live(2);   // separated from the block just freed by one live block
    free_live(1);   // between two free blocks
    drain();
    send_cmd(OP_ALLOC, 16'd40, 16'd0);
    send_cmd(OP_ALLOC, 16'd60000, 16'd0);
    send_cmd(OP_ALLOC, 16'd8, 16'd0);
    drain();

    // Random: sender gaps 25%, then 55%, then back to back.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) gap_pct = 55;
      if (i == 2 * N_RANDOM / 3) gap_pct = 0;
      random_cmd();
    end
    drain();
    repeat (64) @(posedge clk);

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
